/* design/badc_pkg.sv */
package badc_pkg;

   localparam int unsigned DefSampleBits = 20;
   localparam int unsigned DefCalPulses  = 26;

   localparam int unsigned GainW  = 8;
   localparam int unsigned VrefW  = 23;
   localparam int unsigned RawW   = 20;
   localparam int unsigned UvW    = 24;
   localparam int unsigned PulseW = 5;
   localparam int unsigned CsrW   = 23;

   localparam logic [GainW-1:0] GainReset = 8'd64;
   localparam logic [VrefW-1:0] VrefReset = 23'd2500000;

   localparam logic signed [UvW-1:0] UvMax = 24'sh7FFFFF;
   localparam logic signed [UvW-1:0] UvMin = 24'sh800000;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_READ = 3'd1,
      OP_CAL  = 3'd2,
      OP_PDWN = 3'd3,
      OP_WAKE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_READ = 2'd1,
      MODE_CAL  = 2'd2
   } mode_type;

   typedef enum logic {
      CSR_GAIN = 1'b0,
      CSR_VREF = 1'b1
   } csr_idx_type;

   typedef enum logic {
      TOP_IDLE  = 1'b0,
      TOP_SCALE = 1'b1
   } top_state_type;

   typedef enum logic [1:0] {
      SC_IDLE = 2'd0,
      SC_MUL  = 2'd1,
      SC_DIV  = 2'd2,
      SC_DONE = 2'd3
   } scale_state_type;

   typedef struct packed {
      logic sclk;
      logic pdwn;
      logic busy;
      logic done;
   } tick_res_type;

endpackage

/* design/bridge_adc_serial_reader_unit.sv */
// Serial readout master for a 20-bit bridge converter.
// Each transfer on the req_ channel is one one-microsecond tick carrying a
// command and the sampled level of the converter data pin. For every tick
// the block returns one transfer on the rsp_ channel with the clock and
// power-down pin levels, a busy flag and, on the last tick of a read, the
// signed code and its value in microvolts.
// rsp_tvalid rises in the cycle after an ordinary tick is accepted, and
// ordinary ticks can follow back to back, one per cycle while rsp_tready is
// high. The last tick of a read runs the scaling unit: it forms the divisor,
// then the SAMPLE_BITSx23 product, then one restoring-division step per cycle
// over SAMPLE_BITS+23 dividend bits, the last step also loading its output
// register; the result then passes into this block's output register once free.
// req_tready is low while that unit works.
// The user writes gain and reference through the csr_ port only while no
// tick is in flight; the block does not enforce it. Reset idles the sequencer,
// powers the converter down and restores gain 64 and reference 2500000 uV.
// A result waits in the output register while rsp_tready is low; one more
// tick can be accepted only once that register is being emptied.
module bridge_adc_serial_reader_unit #(
   parameter int unsigned SAMPLE_BITS = badc_pkg::DefSampleBits,
   parameter int unsigned CAL_PULSES  = badc_pkg::DefCalPulses
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // opcode[2:0], dout_level[3], zero pad
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [47:0]                 rsp_tdata,  // sclk_level[0], pdwn_level[1],
                                                   // busy_res[2], sample_done[3],
                                                   // raw_value[23:4], microvolts[47:24]
   input  logic                        csr_we,
   input  logic                        csr_addr,
   input  logic [badc_pkg::CsrW-1:0]   csr_wdata
);
   import badc_pkg::*;

   localparam logic signed [24:0] RawMax = 25'sd524287;
   localparam logic signed [24:0] RawMin = -25'sd524288;

   top_state_type           state_ff, state_in;
   logic [GainW-1:0]        gain_ff;
   logic [VrefW-1:0]        vref_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   tick_res_type            out_res_ff, out_res_in;
   logic signed [RawW-1:0]  raw_ff, raw_in;
   logic signed [UvW-1:0]   uv_ff, uv_in;
   tick_res_type            pend_res_ff, pend_res_in;
   logic signed [RawW-1:0]  pend_raw_ff, pend_raw_in;

   tick_res_type            tick_res;
   logic [SAMPLE_BITS-1:0]  code;
   logic signed [24:0]      code_ext;
   logic signed [RawW-1:0]  code_raw;
   logic                    accept;
   logic                    slot_free;
   logic                    scale_start;
   logic                    scale_ack;
   logic                    scale_done;
   logic signed [UvW-1:0]   scale_uv;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == TOP_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   badc_tick_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CAL_PULSES  (CAL_PULSES)
   ) u_tick (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .opcode     (req_tdata[2:0]),
      .dout_level (req_tdata[3]),
      .tick_res   (tick_res),
      .code       (code)
   );

   badc_scale_unit #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .start      (scale_start),
      .ack        (scale_ack),
      .code       (code),
      .gain       (gain_ff),
      .vref       (vref_ff),
      .done       (scale_done),
      .microvolts (scale_uv)
   );

   // Codes wider than the raw field clamp to its signed range.
   assign code_ext = 25'(signed'(code));
   assign code_raw = (code_ext > RawMax) ? RawMax[RawW-1:0] :
                     (code_ext < RawMin) ? RawMin[RawW-1:0] : code_ext[RawW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GainReset;
         vref_ff <= VrefReset;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_GAIN: gain_ff <= csr_wdata[GainW-1:0];
            CSR_VREF: vref_ff <= csr_wdata[VrefW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      raw_ff      <= raw_in;
      uv_ff       <= uv_in;
      pend_res_ff <= pend_res_in;
      pend_raw_ff <= pend_raw_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_res_in   = out_res_ff;
      raw_in       = raw_ff;
      uv_in        = uv_ff;
      pend_res_in  = pend_res_ff;
      pend_raw_in  = pend_raw_ff;
      scale_start  = 1'b0;
      scale_ack    = 1'b0;

      unique case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               if (tick_res.done) begin
                  // Final read tick: hold its pins until the scaled value is ready.
                  scale_start = 1'b1;
                  pend_res_in = tick_res;
                  pend_raw_in = code_raw;
                  state_in    = TOP_SCALE;
               end else begin
                  rsp_valid_in = 1'b1;
                  out_res_in   = tick_res;
                  raw_in       = '0;
                  uv_in        = '0;
               end
            end
         end
         TOP_SCALE: begin
            if (scale_done && slot_free) begin
               scale_ack    = 1'b1;
               rsp_valid_in = 1'b1;
               out_res_in   = pend_res_ff;
               raw_in       = pend_raw_ff;
               uv_in        = scale_uv;
               state_in     = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {uv_ff, raw_ff, out_res_ff.done, out_res_ff.busy,
                        out_res_ff.pdwn, out_res_ff.sclk};

`ifndef SYNTH
   a_done_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_res_ff.done && !out_res_ff.busy))
      else $error("read completion reported outside a sequence");
   a_idle_values_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_res_ff.done) |-> (raw_ff == '0 && uv_ff == '0))
      else $error("value reported on a tick without a completed read");
   a_no_accept_scaling: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TOP_SCALE) |-> !req_tready)
      else $error("tick accepted while scaling");
   a_scale_returns: assert property (@(posedge clock) disable iff (reset)
      scale_ack |=> (state_ff == TOP_IDLE && rsp_valid_ff))
      else $error("scaled result not presented");
`endif

endmodule

/* design/badc_tick_ctrl.sv */
module badc_tick_ctrl #(
   parameter int unsigned SAMPLE_BITS = badc_pkg::DefSampleBits,
   parameter int unsigned CAL_PULSES  = badc_pkg::DefCalPulses
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [2:0]               opcode,
   input  logic                     dout_level,
   output badc_pkg::tick_res_type   tick_res,
   output logic [SAMPLE_BITS-1:0]   code
);
   import badc_pkg::*;

   localparam logic [PulseW-1:0] ReadTotal = PulseW'(SAMPLE_BITS + 1);
   localparam logic [PulseW-1:0] CalTotal  = PulseW'(CAL_PULSES);
   localparam logic [PulseW-1:0] BitsTotal = PulseW'(SAMPLE_BITS);

   mode_type                 mode_ff, mode_in;
   logic [PulseW-1:0]        pulse_ff, pulse_in;
   logic [1:0]               phase_ff, phase_in;
   logic [SAMPLE_BITS-1:0]   shift_ff, shift_in;
   logic                     pdwn_ff, pdwn_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pulse_ff <= '0;
         phase_ff <= '0;
         shift_ff <= '0;
         pdwn_ff  <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         pulse_ff <= pulse_in;
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         pdwn_ff  <= pdwn_in;
      end
   end

   always_comb begin
      logic [PulseW-1:0] total;
      logic [PulseW-1:0] cnt;
      mode_in  = mode_ff;
      pulse_in = pulse_ff;
      phase_in = phase_ff;
      shift_in = shift_ff;
      pdwn_in  = pdwn_ff;
      tick_res = '0;
      total    = '0;
      cnt      = '0;

      if (mode_ff == MODE_IDLE) begin
         unique case (op_type'(opcode))
            OP_READ: begin
               mode_in  = MODE_READ;
               pulse_in = '0;
               phase_in = '0;
               shift_in = '0;
            end
            OP_CAL: begin
               mode_in  = MODE_CAL;
               pulse_in = '0;
               phase_in = '0;
            end
            OP_PDWN: pdwn_in = 1'b0;
            OP_WAKE: pdwn_in = 1'b1;
            default: ;
         endcase
      end

      if (mode_in != MODE_IDLE) begin
         total         = (mode_in == MODE_READ) ? ReadTotal : CalTotal;
         tick_res.busy = 1'b1;
         tick_res.sclk = (phase_in < 2'd2);
         // Data is sampled on the second high tick of each data pulse.
         if (mode_in == MODE_READ && phase_in == 2'd1 && pulse_in < BitsTotal) begin
            shift_in = {shift_in[SAMPLE_BITS-2:0], dout_level};
         end
         if (phase_in == 2'd3) begin
            phase_in = '0;
            cnt      = pulse_in + 1'b1;
            if (cnt >= total) begin
               tick_res.done = (mode_in == MODE_READ);
               mode_in       = MODE_IDLE;
               pulse_in      = '0;
            end else begin
               pulse_in = cnt;
            end
         end else begin
            phase_in = phase_in + 1'b1;
         end
      end
      tick_res.pdwn = pdwn_in;
   end

   assign code = shift_in;

`ifndef SYNTH
   a_done_is_busy: assert property (@(posedge clock) disable iff (reset)
      tick_res.done |-> tick_res.busy)
      else $error("read completion outside a sequence");
   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (phase_ff == 2'd0 && pulse_ff == '0))
      else $error("sequence counters not cleared when idle");
   a_pulse_bound: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_READ) |-> (pulse_ff <= BitsTotal))
      else $error("read pulse count beyond its end");
`endif

endmodule

/* design/badc_scale_unit.sv */
module badc_scale_unit #(
   parameter int unsigned SAMPLE_BITS = badc_pkg::DefSampleBits
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             ack,
   input  logic [SAMPLE_BITS-1:0]           code,
   input  logic [badc_pkg::GainW-1:0]       gain,
   input  logic [badc_pkg::VrefW-1:0]       vref,
   output logic                             done,
   output logic signed [badc_pkg::UvW-1:0]  microvolts
);
   import badc_pkg::*;

   localparam int unsigned CW   = SAMPLE_BITS;
   localparam int unsigned NW   = CW + VrefW;
   localparam int unsigned DENW = GainW + CW - 1;
   localparam int unsigned CNTW = $clog2(NW + 1);
   localparam logic [CW-2:0]   FullScale = {(CW-1){1'b1}};
   localparam logic [CNTW-1:0] LastIter  = CNTW'(NW - 1);

   scale_state_type       state_ff, state_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]         mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  gzero_ff, gzero_in;
   logic [DENW-1:0]       den_ff, den_in;
   logic [DENW-1:0]       rem_ff, rem_in;
   logic [NW-1:0]         num_ff, num_in;
   logic signed [UvW-1:0] uv_ff, uv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      gzero_ff <= gzero_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      uv_ff    <= uv_in;
   end

   always_comb begin
      logic [DENW:0] trial;
      logic          qbit;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      gzero_in = gzero_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      uv_in    = uv_ff;
      trial    = {rem_ff, num_ff[NW-1]};
      qbit     = (trial >= {1'b0, den_ff});

      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               neg_in   = code[CW-1];
               mag_in   = code[CW-1] ? (~code + 1'b1) : code;
               gzero_in = (gain == '0);
               den_in   = DENW'(gain) * DENW'(FullScale);
               state_in = SC_MUL;
            end
         end
         SC_MUL: begin
            num_in   = NW'(mag_ff) * NW'(vref);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = SC_DIV;
         end
         SC_DIV: begin
            // Restoring division: one quotient bit per cycle shifts in behind
            // the dividend bits.
            rem_in = qbit ? DENW'(trial - {1'b0, den_ff}) : trial[DENW-1:0];
            num_in = {num_ff[NW-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastIter) begin
               state_in = SC_DONE;
            end
         end
         SC_DONE: begin
            if (ack) begin
               state_in = SC_IDLE;
            end
         end
         default: state_in = SC_IDLE;
      endcase

      // The quotient is complete once the last bit enters; saturate and sign it, or give zero for a zero gain.
      if (state_ff == SC_DIV && cnt_ff == LastIter) begin
         if (gzero_ff) begin
            uv_in = '0;
         end else if (!neg_ff) begin
            uv_in = (num_in > NW'(UvMax)) ? UvMax : signed'(num_in[UvW-1:0]);
         end else begin
            uv_in = (num_in > NW'(unsigned'(UvMin))) ? UvMin
                                                     : signed'(-num_in[UvW-1:0]);
         end
      end
   end

   assign done       = (state_ff == SC_DONE);
   assign microvolts = uv_ff;

`ifndef SYNTH
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == SC_IDLE))
      else $error("scaling started while the unit is busy");
   a_div_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SC_DIV && cnt_ff == LastIter) |=> done)
      else $error("division did not finish after its last step");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (done && !ack) |=> (done && $stable(microvolts)))
      else $error("scaled result changed before it was taken");
`endif

endmodule
